// ===== rtl/core/b2da_pkg.sv =====
// Shared constants for the binary to decimal ASCII converter.
// No dependencies; used by the channel interfaces and the core.
package b2da_pkg;

  // Width of the input payload field.
  localparam int unsigned InWidth    = 64;
  // Number of low input bits that take part in the conversion (8 to 64).
  localparam int unsigned ValueWidth = 64;
  // Decimal digits of the largest ValueWidth-bit value: floor(W*log10(2)) + 1.
  localparam int unsigned NumDigits  = (ValueWidth * 30103) / 100000 + 1;
  localparam int unsigned BcdWidth   = NumDigits * 4;
  localparam int unsigned BitCntW    = $clog2(ValueWidth);
  localparam int unsigned DigCntW    = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int unsigned CharWidth  = 6;

  // ASCII '0', truncated to the 6-bit character field.
  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

endpackage

// ===== rtl/core/b2da_if.sv =====
// Valid/ready channel interfaces of the binary to decimal ASCII converter.
// Depends on b2da_pkg for the payload widths.
interface b2da_in_if import b2da_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [InWidth-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface b2da_out_if import b2da_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/core/binary_to_decimal_ascii_core.sv =====
// Converts an unsigned binary value to decimal ASCII digits, most significant digit
// first, without leading zeros; the final digit of each number carries last_digit.
// The low ValueWidth bits of value_in are used. An input beat is taken only while the
// core is idle; the core then runs a shift-and-adjust step for each of the ValueWidth bits
// (one input bit per cycle into a BCD shift register) and then walks the BCD register
// one digit per cycle, dropping leading zeros and loading the others into the output
// register; a digit to be loaded waits while the output register holds a digit not yet taken.
// The last digit of a number may wait in the output register while the next beat is taken.
// Depends on b2da_pkg and the channel interfaces in b2da_if.sv.
module binary_to_decimal_ascii_core import b2da_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2da_in_if.sink     in_i,
  b2da_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic                  seen_q, seen_d;
  logic                  out_valid_q, out_valid_d;
  logic [CharWidth-1:0]  out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [BcdWidth-1:0]   bcd_adj;
  logic [3:0]            top_digit;
  logic                  is_last;
  logic                  skip;
  logic                  out_free;
  logic                  load;
  logic                  in_beat;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign in_beat          = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last_digit = out_last_q;

  // Double dabble: add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BcdWidth-1 -: 4];
  assign is_last   = (dig_cnt_q == '0);
  // Drop a leading zero, but never the final digit, so zero still shows as '0'.
  assign skip      = !seen_q && (top_digit == 4'd0) && !is_last;
  assign out_free  = !out_valid_q || out_o.ready;
  assign load      = (state_q == ST_EMIT) && !skip && out_free;

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    // Retire the held beat once the sink takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          bin_d     = in_i.value_in[ValueWidth-1:0];
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        // Shift the next binary bit into the adjusted BCD register.
        bcd_d     = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
        bin_d     = {bin_q[ValueWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitCntW'(ValueWidth - 1)) begin
          dig_cnt_d = DigCntW'(NumDigits - 1);
          seen_d    = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip || load) begin
          // Advance to the next digit.
          bcd_d     = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - 1'b1;
        end
        if (load) begin
          out_valid_d = 1'b1;
          out_char_d  = AsciiZero + {2'b00, top_digit};
          out_last_d  = is_last;
          seen_d      = 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath shift registers and output payload.
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

`ifndef SYNTHESIS
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q >= 6'd48) && (out_char_q <= 6'd57))
    else $error("output character outside '0'..'9'");

  a_beat_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_CONV) && (bit_cnt_q == '0))
    else $error("accepted beat did not start conversion");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_last) |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
    else $error("final digit did not close the item");

  a_bcd_digit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("BCD digit out of range");
`endif

endmodule

// ===== dv/b2da_tb_pkg.sv =====
// Scoreboard for the binary to decimal ASCII converter testbench.
// Depends on b2da_pkg for the value and character widths.
package b2da_tb_pkg;
  import b2da_pkg::*;

  typedef struct packed {
    logic [CharWidth-1:0] digit_char;
    logic                 last_digit;
  } digit_beat_t;

  class digit_scoreboard;
    digit_beat_t pending_digits[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    function int unsigned pending();
      return pending_digits.size();
    endfunction

    // Predict the digit beats of one accepted value, most significant first.
    function void note_value(logic [InWidth-1:0] raw_value);
      logic [63:0]          rest;
      logic [63:0]          digit_val;
      logic [CharWidth-1:0] rev_chars[$];
      logic [7:0]           code;
      digit_beat_t          beat;
      rest = 64'(raw_value) & ({64{1'b1}} >> (64 - ValueWidth));
      do begin
        digit_val = rest % 64'd10;
        code      = 8'd48 + digit_val[7:0];
        rev_chars.push_back(code[CharWidth-1:0]);
        rest      = rest / 64'd10;
      end while (rest != 0 && rev_chars.size() < 20);
      for (int k = rev_chars.size() - 1; k >= 0; k--) begin
        beat.digit_char = rev_chars[k];
        beat.last_digit = (k == 0);
        pending_digits.push_back(beat);
      end
    endfunction

    // Compare one output beat with the oldest predicted digit.
    function void check_digit(logic [CharWidth-1:0] got_char, logic got_last);
      digit_beat_t want;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit beat: expected none actual char %0d last %0b",
                 $time, got_char, got_last);
        error_count++;
        return;
      end
      want = pending_digits.pop_front();
      if (got_char !== want.digit_char) begin
        $display("%0t: digit_char mismatch: expected %0d actual %0d",
                 $time, want.digit_char, got_char);
        error_count++;
      end
      if (got_last !== want.last_digit) begin
        $display("%0t: last_digit mismatch: expected %0b actual %0b",
                 $time, want.last_digit, got_last);
        error_count++;
      end
    endfunction

    function void check_drained();
      if (pending_digits.size() != 0) begin
        $display("%0t: %0d digit beats never arrived: expected %0d actual none",
                 $time, pending_digits.size(), pending_digits[0].digit_char);
        error_count++;
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench of binary_to_decimal_ascii_core: directed and random values,
// digits predicted by the scoreboard in b2da_tb_pkg, random stalls on both channels.
// Depends on b2da_pkg, b2da_if.sv, b2da_tb_pkg and the core.
module tb_top;
  import b2da_pkg::*;
  import b2da_tb_pkg::*;

  // Slowest run: ~470 items, counted at up to 20 digits each, long receiver stalls; taken several times.
  localparam int unsigned CycleLimit  = 1500000;
  // Drain margin after the last digit, sized from ValueWidth and NumDigits.
  localparam int unsigned DrainCycles = 2 * (1 + ValueWidth + NumDigits);

  logic clk_i;
  logic rst_ni;

  b2da_in_if  in_if ();
  b2da_out_if out_if ();

  binary_to_decimal_ascii_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  digit_scoreboard digit_sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     cycle_count;

  // Free-running clock, period 4.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Drive every input to a known value from time zero; hold reset low, then release it at a falling edge.
  initial begin
    digit_sb        = new();
    send_idle_pct   = 14;
    recv_idle_pct   = 78;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.value_in  = '0;
    out_if.ready    = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Receiver: decide ready at each falling edge from the current idle rate.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each digit beat at the rising edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      digit_sb.check_digit(out_if.digit_char, out_if.last_digit);
    end
  end

  // Watchdog: end the run if it never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL binary_to_decimal_ascii_core");
    $finish;
  end

  // Send one value beat. Enter and leave at a falling edge; valid stays high on return
  // so a back-to-back beat never sees valid lowered and raised in one step.
  task automatic send_value(input logic [InWidth-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.value_in <= value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    digit_sb.note_value(value);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every predicted digit has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (digit_sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] pow10(input int unsigned exp10);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < exp10; i++) acc = acc * 64'd10;
    return acc;
  endfunction

  // Random value: full-width noise, a random bit length (so digit counts spread
  // from 1 to 20), or a neighbor of a power of ten where digit counts roll over.
  function automatic logic [InWidth-1:0] random_value();
    logic [63:0]  raw;
    int unsigned  nbits;
    int unsigned  pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(9);
    if (pick < 4) begin
      return raw;
    end else if (pick < 8) begin
      nbits = $urandom_range(1, 64);
      if (nbits < 64) raw = raw & ((64'd1 << nbits) - 64'd1);
      // Set the top bit of the chosen length half of the time.
      if ($urandom_range(1)) raw[nbits-1] = 1'b1;
      return raw;
    end else begin
      return pow10($urandom_range(0, 19)) + 64'($signed($urandom_range(4)) - 2);
    end
  endfunction

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_value(random_value());
      // Pause now and then until the core has emptied.
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [InWidth-1:0] directed_values[$];
    @(posedge rst_ni);
    @(negedge clk_i);

    // Directed part: zero, digit-count edges, extremes, embedded zeros, bit patterns.
    directed_values = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd101, 64'd999, 64'd1000,
      64'd4294967295, 64'd4294967296, 64'd1000000000000000000,
      64'd9999999999999999999, 64'd10000000000000000000, 64'h8000000000000000,
      64'd18446744073709551615, 64'd18446744073709551614, 64'hAAAAAAAAAAAAAAAA,
      64'h5555555555555555, 64'd1000000000000000001, 64'd12345678901234567890,
      64'd100200300400500600
    };
    foreach (directed_values[i]) send_value(directed_values[i]);
    send_random(130);
    wait_drained();

    // Swap the idle rates: slow sender, mostly ready receiver.
    send_idle_pct = 78;
    recv_idle_pct = 14;
    send_random(160);
    wait_drained();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(160);

    // Drop valid, wait for the last digits, then let the core settle.
    in_if.valid <= 1'b0;
    while (digit_sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    digit_sb.check_drained();

    if (digit_sb.error_count == 0) begin
      $display("PASS binary_to_decimal_ascii_core");
    end else begin
      $display("FAIL binary_to_decimal_ascii_core");
    end
    $finish;
  end

endmodule
